### rtl/tle_pkg.sv
package tle_pkg;

  localparam int LINE_LEN = 16;
  localparam int IDX_W    = $clog2(LINE_LEN);

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_INS   = 8'h32;
  localparam logic [7:0] CH_DELK  = 8'h33;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_RUB   = 8'h7f;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LINE_LEN - 1);
  localparam logic [IDX_W-1:0] CUR_MAX  = IDX_W'(LINE_LEN - 2);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_LINE, S_BS_LEFT, S_SHIFT, S_TAIL, S_BSS,
    S_BS_END, S_ESC1, S_LBR, S_CSI_C, S_CHAR_BS, S_CHAR_END
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ESC, PH_CSI, PH_CSI2, PH_CSI3
  } phase_t;

  typedef enum logic [2:0] {
    KEY_NONE, KEY_BYTE, KEY_LEFT, KEY_RIGHT, KEY_DEL
  } key_t;

  typedef enum logic [2:0] {
    SRC_LINE, SRC_TAIL, SRC_BS, SRC_ESC, SRC_LBR, SRC_C, SRC_CHAR
  } src_t;

  typedef struct packed {
    logic load_byte;
    logic emit;
    src_t src;
    logic last;
    logic idx_zero;
    logic idx_cur;
    logic idx_inc;
    logic cur_dec;
    logic cur_inc;
    logic shift;
    logic clear;
    logic wr_char;
    logic wr_space;
  } cmd_t;

  typedef struct packed {
    logic             out_free;
    logic             cur_zero;
    logic             cur_at_max;
    logic             idx_last;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] cursor;
  } sts_t;

endpackage

### rtl/tle_if.sv
interface tle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_tx_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

### rtl/tle_dp.sv
module tle_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  tle_pkg::cmd_t cmd,
  output tle_pkg::sts_t sts,
  input  logic [7:0]    in_byte,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          out_kind,
  output logic [7:0]    out_data,
  output logic          out_last
);
  import tle_pkg::*;

  logic [7:0]       store_r [LINE_LEN];
  logic [7:0]       store_nxt [LINE_LEN];
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       byte_r;
  logic             oval_r, oval_nxt;
  logic             okind_r;
  logic [7:0]       obyte_r;
  logic             olast_r;
  logic [7:0]       rd_byte;
  logic [7:0]       sel_byte;

  assign rd_byte = store_r[idx_r];

  // line store: clear, shift left from cursor, or write at cursor
  always_comb begin
    for (int i = 0; i < LINE_LEN; i++) begin
      store_nxt[i] = store_r[i];
      if (cmd.clear) begin
        store_nxt[i] = '0;
      end else if (cmd.shift && IDX_W'(i) >= cur_r) begin
        store_nxt[i] = (i == LINE_LEN - 1) ? 8'h00 : store_r[(i + 1) % LINE_LEN];
      end else if (cmd.wr_char && IDX_W'(i) == cur_r) begin
        store_nxt[i] = byte_r;
      end else if (cmd.wr_space && IDX_W'(i) == cur_r && store_r[i] == 8'h00) begin
        store_nxt[i] = CH_SPACE;
      end
    end
  end

  always_comb begin
    cur_nxt = cur_r;
    if (cmd.clear) begin
      cur_nxt = '0;
    end else if (cmd.cur_dec) begin
      cur_nxt = cur_r - 1'b1;
    end else if (cmd.cur_inc) begin
      cur_nxt = cur_r + 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_cur) begin
      idx_nxt = cur_r;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    case (cmd.src)
      SRC_LINE: sel_byte = rd_byte;
      SRC_TAIL: sel_byte = (rd_byte == 8'h00) ? CH_SPACE : rd_byte;
      SRC_BS:   sel_byte = CH_BS;
      SRC_ESC:  sel_byte = CH_ESC;
      SRC_LBR:  sel_byte = CH_LBR;
      SRC_C:    sel_byte = CH_RIGHT;
      SRC_CHAR: sel_byte = byte_r;
      default:  sel_byte = byte_r;
    endcase
  end

  always_comb begin
    oval_nxt = oval_r;
    if (cmd.emit) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_LEN; i++) begin
        store_r[i] <= '0;
      end
      cur_r  <= '0;
      idx_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      store_r <= store_nxt;
      cur_r   <= cur_nxt;
      idx_r   <= idx_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r <= in_byte;
    end
    if (cmd.emit) begin
      okind_r <= (cmd.src == SRC_LINE);
      obyte_r <= sel_byte;
      olast_r <= cmd.last;
    end
  end

  assign sts.out_free   = !oval_r || out_ready;
  assign sts.cur_zero   = (cur_r == '0);
  assign sts.cur_at_max = (cur_r == CUR_MAX);
  assign sts.idx_last   = (idx_r == IDX_LAST);
  assign sts.rx_byte    = byte_r;
  assign sts.cursor     = cur_r;

  assign out_valid = oval_r;
  assign out_kind  = okind_r;
  assign out_data  = obyte_r;
  assign out_last  = olast_r;

endmodule

### rtl/tle_ctrl.sv
module tle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tle_pkg::sts_t sts,
  output tle_pkg::cmd_t cmd
);
  import tle_pkg::*;

  state_t state_r, state_nxt;
  phase_t esc_r, esc_nxt;
  key_t   key;
  logic   is_cr;
  logic   is_rub;

  assign is_cr  = (sts.rx_byte == CH_CR);
  assign is_rub = (sts.rx_byte == CH_RUB);

  // escape decoder, evaluated on the held byte
  always_comb begin
    key     = KEY_NONE;
    esc_nxt = PH_IDLE;
    unique case (esc_r)
      PH_ESC: begin
        if (sts.rx_byte == CH_LBR) begin
          esc_nxt = PH_CSI;
        end
      end
      PH_CSI: begin
        if (sts.rx_byte == CH_LEFT) begin
          key = KEY_LEFT;
        end else if (sts.rx_byte == CH_RIGHT) begin
          key = KEY_RIGHT;
        end else if (sts.rx_byte == CH_INS) begin
          esc_nxt = PH_CSI2;
        end else if (sts.rx_byte == CH_DELK) begin
          esc_nxt = PH_CSI3;
        end
      end
      PH_CSI2: key = KEY_NONE;
      PH_CSI3: begin
        if (sts.rx_byte == CH_TILDE) begin
          key = KEY_DEL;
        end
      end
      PH_IDLE: begin
        if ((sts.rx_byte >= CH_SPACE && sts.rx_byte <= CH_TILDE) ||
            sts.rx_byte == CH_BS || is_cr || is_rub) begin
          key = KEY_BYTE;
        end else if (sts.rx_byte == CH_ESC) begin
          esc_nxt = PH_ESC;
        end
      end
      default: esc_nxt = PH_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (key)
          KEY_BYTE: begin
            if (is_cr) begin
              state_nxt = S_LINE;
            end else if (is_rub) begin
              state_nxt = sts.cur_zero ? S_IDLE : S_BS_LEFT;
            end else begin
              state_nxt = sts.cur_at_max ? S_CHAR_BS : S_CHAR_END;
            end
          end
          KEY_DEL:   state_nxt = sts.cur_zero ? S_IDLE : S_SHIFT;
          KEY_LEFT:  state_nxt = sts.cur_zero ? S_IDLE : S_BS_END;
          KEY_RIGHT: state_nxt = sts.cur_at_max ? S_IDLE : S_ESC1;
          KEY_NONE:  state_nxt = S_IDLE;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_SHIFT: state_nxt = S_TAIL;
      default: begin
        if (sts.out_free) begin
          unique case (state_r)
            S_LINE:     state_nxt = sts.idx_last ? S_IDLE : S_LINE;
            S_BS_LEFT:  state_nxt = S_SHIFT;
            S_TAIL:     state_nxt = sts.idx_last ? S_BSS : S_TAIL;
            S_BSS:      state_nxt = sts.idx_last ? S_IDLE : S_BSS;
            S_ESC1:     state_nxt = S_LBR;
            S_LBR:      state_nxt = S_CSI_C;
            S_CHAR_BS:  state_nxt = S_BS_END;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.src  = SRC_BS;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_byte = in_valid;
      end
      S_EXEC: begin
        unique case (key)
          KEY_BYTE: begin
            if (is_cr) begin
              cmd.idx_zero = 1'b1;
            end else if (!is_rub) begin
              cmd.wr_char = 1'b1;
              cmd.cur_inc = !sts.cur_at_max;
            end
          end
          KEY_LEFT:  cmd.cur_dec = !sts.cur_zero;
          KEY_RIGHT: begin
            cmd.wr_space = 1'b1;
            cmd.cur_inc  = !sts.cur_at_max;
          end
          default: cmd.src = SRC_BS;
        endcase
      end
      S_SHIFT: begin
        cmd.shift   = 1'b1;
        cmd.idx_cur = 1'b1;
      end
      S_LINE: begin
        cmd.src = SRC_LINE;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.last    = sts.idx_last;
          cmd.idx_inc = 1'b1;
          cmd.clear   = sts.idx_last;
        end
      end
      S_BS_LEFT: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cur_dec = 1'b1;
        end
      end
      S_TAIL: begin
        cmd.src = SRC_TAIL;
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.idx_cur = sts.idx_last;
          cmd.idx_inc = !sts.idx_last;
        end
      end
      S_BSS: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.last    = sts.idx_last;
          cmd.idx_inc = 1'b1;
        end
      end
      S_BS_END: begin
        cmd.emit = sts.out_free;
        cmd.last = 1'b1;
      end
      S_ESC1: begin
        cmd.src  = SRC_ESC;
        cmd.emit = sts.out_free;
      end
      S_LBR: begin
        cmd.src  = SRC_LBR;
        cmd.emit = sts.out_free;
      end
      S_CSI_C: begin
        cmd.src  = SRC_C;
        cmd.emit = sts.out_free;
        cmd.last = 1'b1;
      end
      S_CHAR_BS: begin
        cmd.src  = SRC_CHAR;
        cmd.emit = sts.out_free;
      end
      S_CHAR_END: begin
        cmd.src  = SRC_CHAR;
        cmd.emit = sts.out_free;
        cmd.last = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      esc_r   <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        esc_r <= esc_nxt;
      end
    end
  end

endmodule

### rtl/terminal_line_editor_core.sv
// Terminal line editor. Takes raw terminal bytes, one word per input, and
// keeps a LINE_LEN-byte line with a cursor (held to at most LINE_LEN-2).
// ESC [ D / ESC [ C move the cursor, ESC [ 3 ~ deletes at a nonzero cursor, 0x7f
// deletes left of it, printable bytes and 0x08 are stored at the cursor,
// ESC [ 2 ~ and all other bytes are dropped. Each input yields zero or more
// result words: echo bytes (kind 0) for the terminal, or on CR the whole
// line (kind 1, LINE_LEN words, unused slots 0) after which the line and
// cursor clear. The final word of an input carries last; inputs that
// produce nothing give no word at all.
// Timing: one input at a time. An input is taken and then decoded in the
// next cycle; then the result words leave at one per cycle while the
// receiver keeps ready high, through a single output register. A delete
// shifts the buffer in its own state, S_SHIFT, before the tail redraw.
// The worst case is a rubout with the cursor at 1, which gives
// 2*LINE_LEN+1 result words; a CR gives LINE_LEN. The next input is taken
// as soon as the last word sits in the output register.
module terminal_line_editor_core (
  input logic      clk,
  input logic      rst_n,
  tle_rx_if.sink   in_ch,
  tle_tx_if.source out_ch
);
  import tle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: escape decode and word ordering
  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // line store, cursor, sweep index and output register
  tle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_ch.rx_byte),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_kind  (out_ch.kind),
    .out_data  (out_ch.out_byte),
    .out_last  (out_ch.last)
  );

`ifndef SYNTHESIS
  // cursor never runs past the last editable slot
  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    sts.cursor <= CUR_MAX)
    else $error("cursor beyond limit");

  // a word is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("output word overwritten");

  // the final line word leaves the line cleared with cursor home
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.src == SRC_LINE && cmd.last) |=> sts.cursor == '0)
    else $error("line not cleared after CR");
`endif

endmodule

### dv/tb_terminal_line_editor_core.sv
module tb_terminal_line_editor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tle_pkg::*;

  // one result word as the block presents it
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } word_t;

  // directed stimulus row: typed rows carry their echo words inline
  // (kind 0, up to three, packed first word in the top byte)
  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic [1:0]  n;
    logic [23:0] words;
  } dir_row_t;

  localparam logic BY_MODEL = 1'b0;
  localparam logic TYPED    = 1'b1;

  localparam int DIR_N           = 25;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int HOLD_CYCLES     = 250;
  localparam int QUIET_LIMIT     = 3000;
  localparam int END_TAIL        = 40;

  localparam int SEND_IDLE  [3] = '{27, 63, 0};
  localparam int RECV_STALL [3] = '{63, 27, 0};

  // Directed part, starting from an empty line with the cursor at 0.
  // Rows marked BY_MODEL are checked against the predictor.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'h00,    TYPED,    2'd0, 24'h0},                         // ignored, low extreme
    '{8'hff,    TYPED,    2'd0, 24'h0},                         // ignored, high extreme
    '{CH_RUB,   TYPED,    2'd0, 24'h0},                         // rubout at line start
    '{CH_ESC,   TYPED,    2'd0, 24'h0},
    '{CH_LBR,   TYPED,    2'd0, 24'h0},
    '{CH_LEFT,  TYPED,    2'd0, 24'h0},                         // left at line start
    '{8'h41,    TYPED,    2'd1, {8'h41, 16'h0}},
    '{CH_SPACE, TYPED,    2'd1, {CH_SPACE, 16'h0}},             // lowest printable
    '{CH_TILDE, TYPED,    2'd1, {CH_TILDE, 16'h0}},             // highest printable
    '{CH_BS,    TYPED,    2'd1, {CH_BS, 16'h0}},                // 0x08 is stored, not a move
    '{CH_ESC,   TYPED,    2'd0, 24'h0},
    '{CH_LBR,   TYPED,    2'd0, 24'h0},
    '{CH_RIGHT, TYPED,    2'd3, {CH_ESC, CH_LBR, CH_RIGHT}},    // right onto an empty slot
    '{CH_ESC,   TYPED,    2'd0, 24'h0},
    '{CH_LBR,   TYPED,    2'd0, 24'h0},
    '{CH_DELK,  TYPED,    2'd0, 24'h0},
    '{CH_TILDE, BY_MODEL, 2'd0, 24'h0},                         // delete key, tail redraw
    '{CH_RUB,   BY_MODEL, 2'd0, 24'h0},                         // rubout mid line
    '{CH_ESC,   TYPED,    2'd0, 24'h0},
    '{CH_LBR,   TYPED,    2'd0, 24'h0},
    '{CH_INS,   TYPED,    2'd0, 24'h0},
    '{CH_TILDE, TYPED,    2'd0, 24'h0},                         // insert key swallowed
    '{CH_ESC,   TYPED,    2'd0, 24'h0},
    '{8'h78,    TYPED,    2'd0, 24'h0},                         // broken escape, byte eaten
    '{CH_CR,    BY_MODEL, 2'd0, 24'h0}                          // whole line out
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // handshake drive, known from time zero
  logic       in_valid = 1'b0;
  logic [7:0] in_byte  = 8'h00;
  logic       rx_ready = 1'b0;

  tle_rx_if in_if ();
  tle_tx_if out_if ();

  assign in_if.valid   = in_valid;
  assign in_if.rx_byte = in_byte;
  assign out_if.ready  = rx_ready;

  terminal_line_editor_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // idling knobs, changed only between phases while the block is drained
  int send_idle_pct  = SEND_IDLE[0];
  int recv_stall_pct = RECV_STALL[0];

  // long receiver hold-off: stimulus bumps the request, receiver serves it
  int hold_reqs   = 0;
  int hold_served = 0;
  int hold_left   = 0;

  int err_count    = 0;
  int quiet_cycles = 0;
  int random_items = 0;

  // ---------------------------------------------------------------------
  // Line editor predictor: own copy of the line, cursor and escape phase.
  // edit_line() leaves the words one input byte causes in step_q.
  // ---------------------------------------------------------------------
  logic [7:0] line_mem [LINE_LEN] = '{default: 8'h00};
  int         cur_pos = 0;
  phase_t     esc_ph  = PH_IDLE;

  word_t step_q[$];
  word_t due_words[$];   // words predicted but not yet seen on out_ch

  function automatic void add_word(logic kind, logic [7:0] data);
    word_t w;
    w.kind = kind;
    w.data = data;
    w.last = 1'b0;
    step_q.push_back(w);
  endfunction

  // advance the escape decoder by one byte and name the key it completes
  function automatic key_t decode_key(logic [7:0] c);
    phase_t ph;
    ph     = esc_ph;
    esc_ph = PH_IDLE;
    case (ph)
      PH_ESC: begin
        if (c == CH_LBR) esc_ph = PH_CSI;
        return KEY_NONE;
      end
      PH_CSI: begin
        if (c == CH_LEFT) return KEY_LEFT;
        if (c == CH_RIGHT) return KEY_RIGHT;
        if (c == CH_INS) esc_ph = PH_CSI2;
        if (c == CH_DELK) esc_ph = PH_CSI3;
        return KEY_NONE;
      end
      PH_CSI2: return KEY_NONE;   // insert key: whatever follows is eaten
      PH_CSI3: return (c == CH_TILDE) ? KEY_DEL : KEY_NONE;
      default: ;
    endcase
    if ((c >= CH_SPACE && c <= CH_TILDE) || c == CH_BS || c == CH_CR || c == CH_RUB)
      return KEY_BYTE;
    if (c == CH_ESC) esc_ph = PH_ESC;
    return KEY_NONE;
  endfunction

  // close the gap at the cursor, redraw the tail, walk the cursor back
  function automatic void delete_char(logic from_left);
    if (cur_pos == 0) return;
    if (from_left) begin
      cur_pos--;
      add_word(1'b0, CH_BS);
    end
    for (int i = cur_pos; i < LINE_LEN - 1; i++) line_mem[i] = line_mem[i + 1];
    line_mem[LINE_LEN - 1] = 8'h00;
    for (int i = cur_pos; i < LINE_LEN; i++)
      add_word(1'b0, (line_mem[i] != 8'h00) ? line_mem[i] : CH_SPACE);
    for (int i = cur_pos; i < LINE_LEN; i++) add_word(1'b0, CH_BS);
  endfunction

  function automatic void edit_line(logic [7:0] c);
    key_t k;
    k = decode_key(c);
    step_q.delete();
    case (k)
      KEY_BYTE: begin
        if (c == CH_CR) begin
          for (int i = 0; i < LINE_LEN; i++) add_word(1'b1, line_mem[i]);
          for (int i = 0; i < LINE_LEN; i++) line_mem[i] = 8'h00;
          cur_pos = 0;
        end else if (c == CH_RUB) begin
          delete_char(1'b1);
        end else begin
          line_mem[cur_pos] = c;
          add_word(1'b0, c);
          // at the end slot the cursor stays and the echo steps back over it
          if (cur_pos < LINE_LEN - 2) cur_pos++;
          else add_word(1'b0, CH_BS);
        end
      end
      KEY_DEL: delete_char(1'b0);
      KEY_LEFT: begin
        if (cur_pos > 0) begin
          cur_pos--;
          add_word(1'b0, CH_BS);
        end
      end
      KEY_RIGHT: begin
        // passing over an empty slot fills it with a space, even at the end
        if (line_mem[cur_pos] == 8'h00) line_mem[cur_pos] = CH_SPACE;
        if (cur_pos < LINE_LEN - 2) begin
          cur_pos++;
          add_word(1'b0, CH_ESC);
          add_word(1'b0, CH_LBR);
          add_word(1'b0, CH_RIGHT);
        end
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want_v);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $realtime, what, got, want_v);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Input side. valid stays up from one word to the next unless an idle
  // cycle is drawn; the predictor runs at the edge the word is taken.
  // ---------------------------------------------------------------------
  task automatic drive_byte(input logic [7:0] b, input logic typed, input logic [1:0] n,
                            input logic [23:0] words);
    word_t w;
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    edit_line(b);
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        w.kind = 1'b0;
        w.data = words[23 - 8 * k -: 8];
        w.last = (k == n - 1);
        due_words.push_back(w);
      end
    end else begin
      foreach (step_q[k]) due_words.push_back(step_q[k]);
    end
  endtask

  // one byte of a key sequence in the random part
  task automatic send_key(input logic [7:0] b);
    drive_byte(b, BY_MODEL, 2'd0, 24'h0);
    random_items++;
  endtask

  task automatic send_csi(input logic [7:0] b);
    send_key(CH_ESC);
    send_key(CH_LBR);
    send_key(b);
  endtask

  // sender stops and waits for every predicted word to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_words.size() != 0);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32'(CH_TILDE), 32'(CH_SPACE)));
  endfunction

  // Mostly well-formed keys with random content; a slice of broken escapes
  // and raw noise. Long typing runs push the cursor to the end slot.
  task automatic send_random_key();
    int         pick;
    int         run;
    logic [7:0] b;
    pick = $urandom_range(99, 0);
    if (pick < 30) begin
      send_key(printable());
    end else if (pick < 34) begin
      send_key(CH_BS);
    end else if (pick < 42) begin
      send_key(CH_RUB);
    end else if (pick < 46) begin
      send_key(CH_CR);
    end else if (pick < 54) begin
      send_csi(CH_LEFT);
    end else if (pick < 62) begin
      send_csi(CH_RIGHT);
    end else if (pick < 70) begin
      send_csi(CH_DELK);
      send_key(CH_TILDE);
    end else if (pick < 73) begin
      send_csi(CH_INS);
      send_key(CH_TILDE);
    end else if (pick < 80) begin
      // broken sequences: each ends on one consumed byte
      case ($urandom_range(3, 0))
        0: begin
          do b = 8'($urandom_range(255, 0)); while (b == CH_LBR);
          send_key(CH_ESC);
          send_key(b);
        end
        1: begin
          do b = 8'($urandom_range(255, 0));
          while (b == CH_LEFT || b == CH_RIGHT || b == CH_INS || b == CH_DELK);
          send_csi(b);
        end
        2: begin
          do b = 8'($urandom_range(255, 0)); while (b == CH_TILDE);
          send_csi(CH_DELK);
          send_key(b);
        end
        default: begin
          send_csi(CH_INS);
          send_key(8'($urandom_range(255, 0)));
        end
      endcase
    end else if (pick < 90) begin
      // raw noise: only counts when it turns out to do something
      drive_byte(8'($urandom_range(255, 0)), BY_MODEL, 2'd0, 24'h0);
      if (step_q.size() > 0) random_items++;
    end else begin
      run = $urandom_range(18, 8);
      repeat (run) send_key(printable());
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: check each taken word against the oldest prediction,
  // then draw ready for the next cycle (or serve a long hold-off).
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    word_t want;
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else begin
      if (out_if.valid && rx_ready) begin
        if (due_words.size() == 0) begin
          report_mismatch("unexpected word", {out_if.kind, out_if.out_byte, out_if.last}, 0);
        end else begin
          want = due_words.pop_front();
          if (out_if.kind !== want.kind) report_mismatch("kind", out_if.kind, want.kind);
          if (out_if.out_byte !== want.data)
            report_mismatch("out_byte", out_if.out_byte, want.data);
          if (out_if.last !== want.last) report_mismatch("last", out_if.last, want.last);
        end
      end
      if (hold_served != hold_reqs) begin
        hold_served <= hold_served + 1;
        hold_left   <= HOLD_CYCLES;
        rx_ready    <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rx_ready  <= 1'b0;
      end else begin
        rx_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // watchdog: too long with no word taken on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && rx_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, under the first idling mix
    for (int r = 0; r < DIR_N; r++)
      drive_byte(DIR_TAB[r].rx, DIR_TAB[r].typed, DIR_TAB[r].n, DIR_TAB[r].words);
    wait_drained();

    // random phases: receiver-heavy idling, sender-heavy, then none;
    // the last opens with a long receiver hold-off so the block backs up
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      if (ph == 2) hold_reqs <= hold_reqs + 1;
      random_items = 0;
      while (random_items < ITEMS_PER_PHASE) send_random_key();
      wait_drained();
    end

    repeat (END_TAIL) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
